// File: design/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Pool geometry, status and request codes, sequencer states, memory words.
// ----------------------------------------------------------------------------
`default_nettype none

package chte_pkg;

  // pool geometry
  localparam int NODE_COUNT     = 512;
  localparam int SLOTS_PER_NODE = 3;
  localparam int KEY_BYTES      = 8;

  localparam int NW  = $clog2(NODE_COUNT);          // node index bits
  localparam int LW  = $clog2(NODE_COUNT + 1);      // link bits, NODE_COUNT = none
  localparam int SW  = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
  localparam int FW  = $clog2(SLOTS_PER_NODE + 1);  // fill count bits
  localparam int HCW = (LW > 9) ? LW : 9;           // holds 1 << BB_MAX

  localparam logic [3:0]  BB_RESET  = 4'd8;
  localparam logic [3:0]  BB_MIN    = 4'd4;
  localparam logic [3:0]  BB_MAX    = 4'd8;
  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [2:0] {
    STS_FOUND     = 3'd0,
    STS_CREATED   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_REMOVED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REQ_LOOKUP        = 2'd0,
    REQ_LOOKUP_CREATE = 2'd1,
    REQ_INSERT        = 2'd2,
    REQ_REMOVE        = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_WALK,
    S_ALLOC,
    S_LINK,
    S_REL
  } fsm_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [63:0] key;
    logic [3:0]  len;
  } entry_t;

  typedef struct packed {
    logic [FW-1:0] fill;
    logic [LW-1:0] link;
  } node_t;

endpackage

`default_nettype wire

// File: design/chte_hash.sv
// ----------------------------------------------------------------------------
// chte_hash: byte-serial DJB2 hash unit
// One key byte per cycle: h = h*33 + byte, seeded with 5381.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_hash import chte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] key,
  input  wire logic [3:0]  len,
  output logic             done,
  output logic [31:0]      hash
);

  logic [63:0] key_r;
  logic [3:0]  len_r;
  logic [3:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] h_r;
  logic [7:0]  byte_sel;

  assign byte_sel = key_r[{cnt_r[2:0], 3'b000} +: 8];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == len_r);
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == len_r) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  // datapath: h*33 as shift and add
  always_ff @(posedge clk) begin
    if (go) begin
      key_r <= key;
      len_r <= len;
      h_r   <= HASH_SEED;
    end else if (run_r && (cnt_r != len_r)) begin
      h_r <= (h_r << 5) + h_r + {24'd0, byte_sel};
    end
  end

  assign done = done_r;
  assign hash = h_r;

endmodule

`default_nettype wire

// File: design/chte_core.sv
// ----------------------------------------------------------------------------
// chte_core: chain walker and table memories
// Node memory (fill, link) and entry memory, both with registered reads,
// driven by a sequencer that walks one node per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_core import chte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_key,
  input  wire logic [3:0]  in_key_len,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  output logic             busy,
  output logic             hash_go,
  output logic [63:0]      hash_key,
  output logic [3:0]       hash_len,
  input  wire logic        hash_done,
  input  wire logic [31:0] hash_val,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [8:0]       out_node_index,
  output logic [1:0]       out_slot_index,
  output logic [31:0]      out_key_hash
);

  // memories
  node_t  node_mem  [NODE_COUNT];
  entry_t entry_mem [NODE_COUNT][SLOTS_PER_NODE];
  node_t  node_q_r;
  entry_t ent_q_r   [SLOTS_PER_NODE];

  // registers
  fsm_t          state_r, state_nxt;
  logic [3:0]    bucket_r;
  logic [NW-1:0] clr_idx_r, clr_idx_nxt;
  req_t          req_r;
  logic [63:0]   key_r;
  logic [3:0]    len_r;
  logic [31:0]   hash_r, hash_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] prev_r, prev_nxt;
  logic [FW-1:0] prev_fill_r, prev_fill_nxt;
  logic          prev_ok_r, prev_ok_nxt;
  logic          mode_last_r, mode_last_nxt;
  logic [NW-1:0] hit_node_r, hit_node_nxt;
  logic [SW-1:0] hit_slot_r, hit_slot_nxt;
  logic [NW-1:0] last_r, last_nxt;
  logic [FW-1:0] last_fill_r, last_fill_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [NW-1:0] out_node_r;
  logic [SW-1:0] out_slot_r;
  logic [31:0]   out_hash_r;

  // memory port controls
  logic          nd_we, en_we, rd_en;
  logic [NW-1:0] nd_wa, en_wa, rd_a;
  node_t         nd_wd;
  logic [SW-1:0] en_ws;
  entry_t        en_wd;

  // result controls
  logic          res_fire;
  status_t       res_status;
  logic [NW-1:0] res_node;
  logic [SW-1:0] res_slot;

  // head count from bucket bits, saturated then capped by the pool
  logic [3:0]     bb_eff;
  logic [HCW-1:0] head_w;
  logic [LW-1:0]  head_cnt, head_mask;

  always_comb begin
    bb_eff = bucket_r;
    if (bucket_r < BB_MIN) bb_eff = BB_MIN;
    if (bucket_r > BB_MAX) bb_eff = BB_MAX;
    head_w = HCW'(1) << bb_eff;
    head_cnt = (head_w > HCW'(NODE_COUNT)) ? LW'(NODE_COUNT) : head_w[LW-1:0];
    head_mask = head_cnt - LW'(1);
  end

  // request normalization: clamp length, zero unused key bytes
  logic [3:0]  len_c;
  logic [63:0] key_m;

  always_comb begin
    len_c = (in_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_len;
    for (int b = 0; b < 8; b++) begin
      key_m[b*8 +: 8] = (4'(b) < len_c) ? in_key[b*8 +: 8] : 8'd0;
    end
  end

  assign hash_go  = (state_r == S_IDLE) && start;
  assign hash_key = key_m;
  assign hash_len = len_c;

  // node decode and slot compare
  entry_t        new_ent;
  logic [FW-1:0] fill_c;
  logic [LW-1:0] link_raw;
  logic [NW-1:0] link_n;
  logic          at_end, hit;
  logic [SW-1:0] hit_s;

  assign new_ent  = '{hash: hash_r, key: key_r, len: len_r};
  assign link_raw = node_q_r.link;
  assign link_n   = link_raw[NW-1:0];
  assign at_end   = (link_raw == '0) || (link_raw >= LW'(NODE_COUNT));
  assign fill_c   = (node_q_r.fill > FW'(SLOTS_PER_NODE)) ? FW'(SLOTS_PER_NODE)
                                                          : node_q_r.fill;

  always_comb begin
    hit   = 1'b0;
    hit_s = '0;
    for (int s = SLOTS_PER_NODE - 1; s >= 0; s--) begin
      if ((FW'(s) < fill_c) && (ent_q_r[s] == new_ent)) begin
        hit   = 1'b1;
        hit_s = SW'(s);
      end
    end
  end

  // walk decisions
  logic          srch, found_done, miss_done, go_next, end_create, end_remove;
  logic          full_node, pool_empty, rem_empty, rel;
  logic [FW-1:0] ls;
  logic [NW-1:0] hole_node;
  logic [SW-1:0] hole_slot;

  assign srch       = !mode_last_r;
  assign found_done = srch && hit && (req_r != REQ_REMOVE);
  assign miss_done  = srch && !hit && at_end && (req_r != REQ_LOOKUP_CREATE);
  assign go_next    = !found_done && !at_end;
  assign end_create = at_end && ((srch && !hit && (req_r == REQ_LOOKUP_CREATE)) ||
                                 (mode_last_r && (req_r == REQ_INSERT)));
  assign end_remove = at_end && ((srch && hit && (req_r == REQ_REMOVE)) ||
                                 (mode_last_r && (req_r != REQ_INSERT)));
  assign full_node  = node_q_r.fill >= FW'(SLOTS_PER_NODE);
  assign pool_empty = free_head_r >= LW'(NODE_COUNT);
  assign rem_empty  = node_q_r.fill == '0;
  assign ls         = fill_c - FW'(1);
  assign rel        = (ls == '0) && prev_ok_r && ({1'b0, cur_r} >= head_cnt);
  assign hole_node  = srch ? cur_r : hit_node_r;
  assign hole_slot  = srch ? hit_s : hit_slot_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_idx_r == NW'(NODE_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_HASH;
      S_HASH:  if (hash_done) state_nxt = S_WALK;
      S_WALK: begin
        if (found_done || miss_done) begin
          state_nxt = S_IDLE;
        end else if (go_next) begin
          state_nxt = S_WALK;
        end else if (end_create) begin
          state_nxt = (full_node && !pool_empty) ? S_ALLOC : S_IDLE;
        end else begin
          state_nxt = (end_remove && !rem_empty && rel) ? S_REL : S_IDLE;
        end
      end
      S_ALLOC: state_nxt = S_LINK;
      S_LINK:  state_nxt = S_IDLE;
      S_REL:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  // datapath, memory ports and result
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    hash_nxt      = hash_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_fill_nxt = prev_fill_r;
    prev_ok_nxt   = prev_ok_r;
    mode_last_nxt = mode_last_r;
    hit_node_nxt  = hit_node_r;
    hit_slot_nxt  = hit_slot_r;
    last_nxt      = last_r;
    last_fill_nxt = last_fill_r;
    free_head_nxt = free_head_r;
    nd_we = 1'b0; nd_wa = cur_r; nd_wd = node_q_r;
    en_we = 1'b0; en_wa = cur_r; en_ws = '0; en_wd = new_ent;
    rd_en = 1'b0; rd_a  = cur_r;
    res_fire = 1'b0; res_status = STS_NOT_FOUND; res_node = '0; res_slot = '0;

    case (state_r)
      // rebuild heads and free list, one node a cycle
      S_CLEAR: begin
        nd_we = 1'b1;
        nd_wa = clr_idx_r;
        nd_wd.fill = '0;
        nd_wd.link = ({1'b0, clr_idx_r} < head_cnt) ? '0 : ({1'b0, clr_idx_r} + LW'(1));
        clr_idx_nxt   = clr_idx_r + NW'(1);
        free_head_nxt = head_cnt;
      end
      S_IDLE: ;
      // hash ready: fetch bucket head
      S_HASH: begin
        if (hash_done) begin
          hash_nxt      = hash_val;
          cur_nxt       = hash_val[NW-1:0] & head_mask[NW-1:0];
          prev_ok_nxt   = 1'b0;
          mode_last_nxt = (req_r == REQ_INSERT);
          rd_en = 1'b1;
          rd_a  = hash_val[NW-1:0] & head_mask[NW-1:0];
        end
      end
      S_WALK: begin
        if (found_done) begin
          res_fire = 1'b1; res_status = STS_FOUND; res_node = cur_r; res_slot = hit_s;
        end else if (miss_done) begin
          res_fire = 1'b1; res_status = STS_NOT_FOUND;
        end else if (go_next) begin
          // step to the next node; a remove hit switches to the tail walk
          if (srch && hit) begin
            hit_node_nxt = cur_r;
            hit_slot_nxt = hit_s;
          end
          mode_last_nxt = mode_last_r | hit;
          prev_nxt      = cur_r;
          prev_fill_nxt = node_q_r.fill;
          prev_ok_nxt   = 1'b1;
          cur_nxt       = link_n;
          rd_en = 1'b1;
          rd_a  = link_n;
        end else if (end_create) begin
          if (full_node) begin
            if (pool_empty) begin
              res_fire = 1'b1; res_status = STS_FULL;
            end else begin
              last_nxt      = cur_r;
              last_fill_nxt = node_q_r.fill;
              cur_nxt       = free_head_r[NW-1:0];
              rd_en = 1'b1;
              rd_a  = free_head_r[NW-1:0];
            end
          end else begin
            nd_we = 1'b1; nd_wa = cur_r;
            nd_wd.fill = node_q_r.fill + FW'(1);
            nd_wd.link = link_raw;
            en_we = 1'b1; en_wa = cur_r; en_ws = SW'(node_q_r.fill);
            res_fire = 1'b1; res_status = STS_CREATED;
            res_node = cur_r; res_slot = SW'(node_q_r.fill);
          end
        end else begin
          // remove: tail entry fills the hole, an emptied non-head tail is released
          if (!rem_empty) begin
            nd_we = 1'b1; nd_wa = cur_r;
            nd_wd.fill = ls;
            nd_wd.link = rel ? free_head_r : link_raw;
            en_we = 1'b1; en_wa = hole_node; en_ws = hole_slot;
            en_wd = ent_q_r[ls[SW-1:0]];
          end
          if (!rem_empty && rel) begin
            free_head_nxt = {1'b0, cur_r};
            hit_node_nxt  = hole_node;
            hit_slot_nxt  = hole_slot;
          end else begin
            res_fire = 1'b1; res_status = STS_REMOVED;
            res_node = hole_node; res_slot = hole_slot;
          end
        end
      end
      // fresh node: take it off the free list and fill slot zero
      S_ALLOC: begin
        free_head_nxt = node_q_r.link;
        nd_we = 1'b1; nd_wa = cur_r;
        nd_wd.fill = FW'(1);
        nd_wd.link = '0;
        en_we = 1'b1; en_wa = cur_r; en_ws = '0;
      end
      S_LINK: begin
        nd_we = 1'b1; nd_wa = last_r;
        nd_wd.fill = last_fill_r;
        nd_wd.link = {1'b0, cur_r};
        res_fire = 1'b1; res_status = STS_CREATED; res_node = cur_r; res_slot = '0;
      end
      S_REL: begin
        nd_we = 1'b1; nd_wa = prev_r;
        nd_wd.fill = prev_fill_r;
        nd_wd.link = '0;
        res_fire = 1'b1; res_status = STS_REMOVED;
        res_node = hit_node_r; res_slot = hit_slot_r;
      end
      default: ;
    endcase
    if (cfg_we) clr_idx_nxt = '0;
  end

  // node memory
  always_ff @(posedge clk) begin
    if (nd_we) node_mem[nd_wa] <= nd_wd;
    if (rd_en) node_q_r <= node_mem[rd_a];
  end

  // entry memory, whole node read, one slot written
  always_ff @(posedge clk) begin
    if (en_we) entry_mem[en_wa][en_ws] <= en_wd;
    if (rd_en) begin
      for (int s = 0; s < SLOTS_PER_NODE; s++) ent_q_r[s] <= entry_mem[rd_a][s];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bucket_r    <= BB_RESET;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      mode_last_r <= 1'b0;
      prev_ok_r   <= 1'b0;
      free_head_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= res_fire;
      mode_last_r <= mode_last_nxt;
      prev_ok_r   <= prev_ok_nxt;
      free_head_r <= free_head_nxt;
      if (cfg_we) bucket_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (hash_go) begin
      req_r <= req_t'(in_req_type);
      key_r <= key_m;
      len_r <= len_c;
    end
    hash_r      <= hash_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_fill_r <= prev_fill_nxt;
    hit_node_r  <= hit_node_nxt;
    hit_slot_r  <= hit_slot_nxt;
    last_r      <= last_nxt;
    last_fill_r <= last_fill_nxt;
    if (res_fire) begin
      out_status_r <= res_status;
      out_node_r   <= res_node;
      out_slot_r   <= res_slot;
      out_hash_r   <= hash_r;
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = 9'(out_node_r);
  assign out_slot_index = 2'(out_slot_r);
  assign out_key_hash   = out_hash_r;

endmodule

`default_nettype wire

// File: design/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit: hash table with separate chaining
// DJB2-hashed keys, chains of three-entry nodes over a fixed node pool.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  request   in_req_type, in_key, in_key_len         start & !busy
//  result    out_status, out_node_index,              out_valid, one cycle
//            out_slot_index, out_key_hash
//  config    cfg_wdata (bucket_bits)                  cfg_we
//
//  A request runs serial hashing of the key bytes, a walk along the chain node
//  by node, and the ALLOC and LINK steps for node allocation or the REL step
//  for release; the result word shows in the cycle after the last step.
//  Reset and every cfg write run a clearing pass over all NODE_COUNT (512)
//  nodes of the node memory, busy high throughout.
//  The receiver cannot stall; each result word is valid for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_engine_unit import chte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_key,
  input  wire logic [3:0]  in_key_len,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [8:0]       out_node_index,
  output logic [1:0]       out_slot_index,
  output logic [31:0]      out_key_hash
);

  logic        hash_go, hash_done;
  logic [63:0] hash_key;
  logic [3:0]  hash_len;
  logic [31:0] hash_val;

  chte_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (hash_go),
    .key   (hash_key),
    .len   (hash_len),
    .done  (hash_done),
    .hash  (hash_val)
  );

  chte_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_key_len     (in_key_len),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .busy           (busy),
    .hash_go        (hash_go),
    .hash_key       (hash_key),
    .hash_len       (hash_len),
    .hash_done      (hash_done),
    .hash_val       (hash_val),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_slot_index (out_slot_index),
    .out_key_hash   (out_key_hash)
  );

endmodule

`default_nettype wire

// File: design/chte_checker.sv
// ----------------------------------------------------------------------------
// chte_checker: port-level checks of the hash table engine
// Watches request, result and config ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_checker import chte_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_req_type,
  input wire logic [63:0] in_key,
  input wire logic [3:0]  in_key_len,
  input wire logic        cfg_we,
  input wire logic [3:0]  cfg_wdata,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [8:0]  out_node_index,
  input wire logic [1:0]  out_slot_index,
  input wire logic [31:0] out_key_hash
);

  // accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> busy)
    else $error("request accepted but block not busy");

  // a result word is a single-cycle strobe
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // result only shows once the sequencer is back idle
  a_idle_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(cfg_we)) |-> !busy)
    else $error("result word while busy");

  // misses and full answers carry no location
  a_no_location: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_NOT_FOUND || out_status == STS_FULL)) |->
      (out_node_index == 9'd0 && out_slot_index == 2'd0))
    else $error("miss or full word with nonzero location");

  // reset and config writes start the clearing pass
  a_clear_busy: assert property (@(posedge clk)
    (!rst_n || cfg_we) |=> busy)
    else $error("no clearing pass after reset or config write");

endmodule

bind chained_hash_table_engine_unit chte_checker u_chk (.*);

`default_nettype wire

// File: dv/chained_hash_table_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit_tb: self-checking bench for the hash engine
// Drives lookup/create/insert/remove requests over several bucket counts.
// A shadow table inside a small scoreboard class predicts each result word.
// Results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chte_pkg::*;

  localparam int ENTRIES    = NODE_COUNT * SLOTS_PER_NODE;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    status_t     status;
    logic [8:0]  node;
    logic [1:0]  slot;
    logic [31:0] hash;
  } answer_t;

  // shadow hash table and queue of predicted answers
  class table_scoreboard;
    logic [31:0] ent_hash[ENTRIES];
    logic [63:0] ent_key[ENTRIES];
    int          ent_len[ENTRIES];
    int          fill[NODE_COUNT];
    int          nlink[NODE_COUNT];
    int          free_head;
    int          heads;
    int          errors;
    answer_t     pending[$];

    function void clear_table(logic [3:0] bb);
      int eff;
      eff = bb;
      if (eff < BB_MIN) eff = BB_MIN;
      if (eff > BB_MAX) eff = BB_MAX;
      heads = 1 << eff;
      if (heads > NODE_COUNT) heads = NODE_COUNT;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_hash[i] = '0;
        ent_key[i]  = '0;
        ent_len[i]  = 0;
      end
      for (int i = 0; i < NODE_COUNT; i++) begin
        fill[i]  = 0;
        nlink[i] = (i < heads) ? 0 : i + 1;
      end
      free_head = heads;
    endfunction

    function int next_of(int n);
      return (nlink[n] < NODE_COUNT) ? nlink[n] : 0;
    endfunction

    function bit find(int head, logic [31:0] h, logic [63:0] k, int len,
                      output int node, output int slot, output int prev);
      int cur;
      int back;
      cur  = head;
      back = NODE_COUNT;
      node = 0;
      slot = 0;
      prev = NODE_COUNT;
      for (int st = 0; st < NODE_COUNT; st++) begin
        for (int s = 0; s < fill[cur] && s < SLOTS_PER_NODE; s++) begin
          int e;
          e = cur * SLOTS_PER_NODE + s;
          if (ent_hash[e] == h && ent_len[e] == len && ent_key[e] == k) begin
            node = cur;
            slot = s;
            prev = back;
            return 1;
          end
        end
        if (next_of(cur) == 0) return 0;
        back = cur;
        cur  = next_of(cur);
      end
      return 0;
    endfunction

    function int tail_of(int n, inout int prev);
      for (int st = 0; st < NODE_COUNT && next_of(n) != 0; st++) begin
        prev = n;
        n    = next_of(n);
      end
      return n;
    endfunction

    function bit append(int head, logic [31:0] h, logic [63:0] k, int len,
                        output int node, output int slot);
      int prev;
      int last;
      int fresh;
      int e;
      prev = NODE_COUNT;
      node = 0;
      slot = 0;
      last = tail_of(head, prev);
      if (fill[last] >= SLOTS_PER_NODE) begin
        fresh = free_head;
        if (fresh >= NODE_COUNT) return 0;
        free_head    = nlink[fresh];
        fill[fresh]  = 0;
        nlink[fresh] = 0;
        nlink[last]  = fresh;
        last         = fresh;
      end
      e = last * SLOTS_PER_NODE + fill[last];
      ent_hash[e] = h;
      ent_key[e]  = k;
      ent_len[e]  = len;
      node = last;
      slot = fill[last];
      fill[last]++;
      return 1;
    endfunction

    // accepted request word: update shadow table, queue the predicted answer
    function void note_request(req_t req, logic [63:0] key_in, logic [3:0] len_in);
      int          len;
      logic [63:0] k;
      logic [31:0] h;
      int          head;
      int          node;
      int          slot;
      int          prev;
      int          last;
      int          ls;
      answer_t     a;
      len = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
      k   = key_in;
      if (len < 8) k = k & ((64'd1 << (len * 8)) - 64'd1);
      h = HASH_SEED;
      for (int i = 0; i < len; i++) h = h * 32'd33 + 32'(k[i*8 +: 8]);
      head = h & (heads - 1);
      node = 0;
      slot = 0;
      if (req == REQ_INSERT) begin
        a.status = append(head, h, k, len, node, slot) ? STS_CREATED : STS_FULL;
      end else if (find(head, h, k, len, node, slot, prev)) begin
        a.status = STS_FOUND;
        if (req == REQ_REMOVE) begin
          a.status = STS_REMOVED;
          last = tail_of(node, prev);
          if (fill[last] > 0) begin
            ls = fill[last] - 1;
            if (ls >= SLOTS_PER_NODE) ls = SLOTS_PER_NODE - 1;
            fill[last] = ls;
            ent_hash[node*SLOTS_PER_NODE+slot] = ent_hash[last*SLOTS_PER_NODE+ls];
            ent_key[node*SLOTS_PER_NODE+slot]  = ent_key[last*SLOTS_PER_NODE+ls];
            ent_len[node*SLOTS_PER_NODE+slot]  = ent_len[last*SLOTS_PER_NODE+ls];
            // emptied non-head tail goes back on the free list
            if (ls == 0 && prev < NODE_COUNT && last >= heads) begin
              nlink[prev] = 0;
              nlink[last] = free_head;
              free_head   = last;
            end
          end
        end
      end else if (req == REQ_LOOKUP_CREATE) begin
        a.status = append(head, h, k, len, node, slot) ? STS_CREATED : STS_FULL;
      end else begin
        a.status = STS_NOT_FOUND;
      end
      if (a.status == STS_NOT_FOUND || a.status == STS_FULL) begin
        node = 0;
        slot = 0;
      end
      a.node = 9'(node);
      a.slot = 2'(slot);
      a.hash = h;
      pending.push_back(a);
    endfunction

    function void check_result(logic [2:0] st, logic [8:0] nd, logic [1:0] sl,
                               logic [31:0] hs);
      answer_t a;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word status=%0d", $time, st);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (st !== a.status) begin
        $display("%0t: status exp %0d got %0d", $time, a.status, st);
        errors++;
      end
      if (nd !== a.node) begin
        $display("%0t: node_index exp %0d got %0d", $time, a.node, nd);
        errors++;
      end
      if (sl !== a.slot) begin
        $display("%0t: slot_index exp %0d got %0d", $time, a.slot, sl);
        errors++;
      end
      if (hs !== a.hash) begin
        $display("%0t: key_hash exp %h got %h", $time, a.hash, hs);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = '0;
  logic [63:0] in_key = '0;
  logic [3:0]  in_key_len = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [8:0]  out_node_index;
  logic [1:0]  out_slot_index;
  logic [31:0] out_key_hash;

  table_scoreboard sb = new();
  int          stalled_cycles = 0;
  bit          gaps_on = 1'b1;
  logic [63:0] key_pool[24];
  logic [3:0]  len_pool[24];

  always #2 clk = ~clk;

  chained_hash_table_engine_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_key, .in_key_len,
    .cfg_we, .cfg_wdata, .out_valid, .out_status, .out_node_index,
    .out_slot_index, .out_key_hash
  );

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_node_index, out_slot_index, out_key_hash);
    if (out_valid || (start && !busy) || !rst_n) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // one request word; start stays high until accepted
  task automatic send_word(req_t req, logic [63:0] k, logic [3:0] len);
    if (gaps_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_key      <= k;
    in_key_len  <= len;
    do @(posedge clk); while (busy);
    sb.note_request(req, k, len);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_bucket_bits(logic [3:0] bb);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= bb;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.clear_table(bb);
  endtask

  task automatic random_phase(int count);
    int          pick;
    int          r;
    logic [63:0] k;
    logic [3:0]  len;
    req_t        req;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(23);
      if ($urandom_range(9) == 0) begin
        k   = {$urandom(), $urandom()};
        len = 4'($urandom_range(15));
      end else begin
        // pool keys, with noise above the valid length
        k   = key_pool[pick] ^ ({$urandom(), $urandom()} << (len_pool[pick] * 8));
        if (len_pool[pick] >= 8) k = key_pool[pick];
        len = len_pool[pick];
      end
      r = $urandom_range(99);
      req = (r < 20) ? REQ_LOOKUP : (r < 45) ? REQ_LOOKUP_CREATE :
            (r < 72) ? REQ_INSERT : REQ_REMOVE;
      send_word(req, k, len);
    end
  endtask

  initial begin
    sb.clear_table(BB_RESET);
    for (int i = 0; i < 24; i++) begin
      len_pool[i] = 4'($urandom_range(8));
      key_pool[i] = {$urandom(), $urandom()};
      if (len_pool[i] < 8)
        key_pool[i] = key_pool[i] & ((64'd1 << (len_pool[i] * 8)) - 64'd1);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of key and length, each op, misses, chain growth
    send_word(REQ_LOOKUP, '0, 4'd0);
    send_word(REQ_REMOVE, '1, 4'd8);
    send_word(REQ_LOOKUP_CREATE, '1, 4'd8);
    send_word(REQ_LOOKUP_CREATE, '1, 4'd15);
    send_word(REQ_LOOKUP, '1, 4'd9);
    send_word(REQ_INSERT, '1, 4'd0);
    send_word(REQ_LOOKUP, '0, 4'd0);
    send_word(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FF5A, 4'd1);
    send_word(REQ_LOOKUP, 64'h0000_0000_0000_005A, 4'd1);
    repeat (4) send_word(REQ_INSERT, 64'h1234, 4'd2);
    send_word(REQ_REMOVE, 64'h1234, 4'd2);
    send_word(REQ_REMOVE, 64'h1234, 4'd2);
    send_word(REQ_LOOKUP, 64'h1234, 4'd2);
    send_word(REQ_REMOVE, '1, 4'd8);
    send_word(REQ_REMOVE, '1, 4'd8);
    send_word(REQ_LOOKUP, '1, 4'd8);

    // pool exhaustion: duplicates into one bucket until full
    write_bucket_bits(4'd8);
    gaps_on = 1'b0;
    for (int i = 0; i < (NODE_COUNT - 256 + 1) * SLOTS_PER_NODE + 3; i++)
      send_word(REQ_INSERT, 64'h77, 4'd1);
    send_word(REQ_LOOKUP_CREATE, 64'h88, 4'd1);
    repeat (5) send_word(REQ_REMOVE, 64'h77, 4'd1);
    gaps_on = 1'b1;

    // random phases over several bucket counts, one without gaps
    write_bucket_bits(4'd4);
    random_phase(35);
    gaps_on = 1'b0;
    random_phase(25);
    gaps_on = 1'b1;
    write_bucket_bits(4'd0);
    random_phase(35);
    write_bucket_bits(4'd15);
    random_phase(35);
    write_bucket_bits(4'd5);
    random_phase(35);
    write_bucket_bits(4'd7);
    random_phase(35);
    write_bucket_bits(4'd6);
    random_phase(35);

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/chte_pkg.sv
design/chte_hash.sv
design/chte_core.sv
design/chained_hash_table_engine_unit.sv
design/chte_checker.sv
dv/chained_hash_table_engine_unit_tb.sv
